// ----- src/rcc_pkg.sv -----
// rcc_pkg: shared types and constants of the riff cartridge chunk parser
// used by rcc_parse_core and riff_cartridge_chunk_parser; no dependencies
`default_nettype none

package rcc_pkg;

   // default geometry of the image memory
   localparam int DefPageBytes = 16 * 1024;
   localparam int DefMaxPages  = 32;

   // fixed field widths of the result
   localparam int ADDR_W  = 19;
   localparam int PAGES_W = 6;

   // file format constants
   localparam logic [31:0] MAGIC_RIFF    = 32'h5249_4646;
   localparam logic [31:0] MAGIC_AMS     = 32'h414D_5321;
   localparam logic [3:0]  FILE_HDR_LEN  = 4'd12;
   localparam logic [3:0]  CHUNK_HDR_LEN = 4'd8;
   localparam logic [3:0]  MAGIC_LEN     = 4'd4;
   localparam logic [31:0] HDR_OFFSET    = 32'd12;

   // parser phase, one-hot
   typedef enum logic [4:0] {
      PH_HEADER    = 5'b00001,
      PH_CHUNK_HDR = 5'b00010,
      PH_DATA      = 5'b00100,
      PH_SKIP      = 5'b01000,
      PH_WAIT      = 5'b10000
   } rcc_phase_type;

   // one result transaction
   typedef struct packed {
      logic               write_valid;
      logic [ADDR_W-1:0]  write_address;
      logic [7:0]         write_data;
      logic               clear_image;
      logic               done_res;
      logic               status;
      logic [PAGES_W-1:0] pages_loaded;
   } rcc_result_type;

   // or a little-endian byte into a 32-bit word at byte lane idx
   function automatic logic [31:0] place_byte(input logic [31:0] word,
                                              input logic [1:0]  idx,
                                              input logic [7:0]  b);
      logic [4:0] sh;
      sh = {idx, 3'b000};
      return word | ({24'd0, b} << sh);
   endfunction

endpackage

`default_nettype wire

// ----- src/rcc_parse_core.sv -----
// rcc_parse_core: parser state and per-byte next-state / result logic
// depends on rcc_pkg; the result is combinational and registered by the top level
`default_nettype none

module rcc_parse_core import rcc_pkg::*; #(
   parameter int PAGE_BYTES = DefPageBytes,
   parameter int MAX_PAGES  = DefMaxPages
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic [7:0]     in_byte,
   input  wire logic           in_last,
   output rcc_result_type      result
);

   localparam int PAGE_W = $clog2(MAX_PAGES + 1);
   localparam int KEEP_W = $clog2(PAGE_BYTES + 2);
   localparam logic [ADDR_W-1:0] PAGE_STEP  = ADDR_W'(PAGE_BYTES);
   localparam logic [KEEP_W-1:0] PAGE_KEEP  = KEEP_W'(PAGE_BYTES);
   localparam logic [31:0]       PAGE_WORD  = 32'(PAGE_BYTES);
   localparam logic [PAGE_W-1:0] PAGE_LIMIT = PAGE_W'(MAX_PAGES);

   rcc_phase_type     phase_ff, phase_in;
   logic [3:0]        count_ff, count_in;
   logic [31:0]       magic_ff, magic_in;
   logic [31:0]       total_ff, total_in;
   logic [31:0]       offset_ff, offset_in;
   logic [31:0]       chunk_len_ff, chunk_len_in;
   logic [KEEP_W-1:0] keep_ff, keep_in;
   logic [KEEP_W-1:0] pos_ff, pos_in;
   logic [31:0]       skip_ff, skip_in;
   logic              skip_flag_ff, skip_flag_in;
   logic [PAGE_W-1:0] page_ff, page_in;
   logic [ADDR_W-1:0] base_ff, base_in;

   logic [31:0]       len_next;
   logic [KEEP_W-1:0] kept_raw;
   logic [KEEP_W-1:0] kept;
   logic              go_next;
   rcc_result_type    res;

   // chunk length with this byte, and the kept length of a chunk whose header completes now
   always_comb begin
      if (count_ff[3:2] == 2'b01) begin
         len_next = place_byte(chunk_len_ff, count_ff[1:0], in_byte);
      end else begin
         len_next = chunk_len_ff;
      end
      if (len_next < PAGE_WORD) begin
         kept_raw = len_next[KEEP_W-1:0];
      end else begin
         kept_raw = PAGE_KEEP;
      end
      kept = kept_raw + KEEP_W'(kept_raw[0]);
   end

   // next state and result for one byte
   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      magic_in     = magic_ff;
      total_in     = total_ff;
      offset_in    = offset_ff;
      chunk_len_in = chunk_len_ff;
      keep_in      = keep_ff;
      pos_in       = pos_ff;
      skip_in      = skip_ff;
      skip_flag_in = skip_flag_ff;
      page_in      = page_ff;
      base_in      = base_ff;
      go_next      = 1'b0;
      res          = '0;

      unique case (phase_ff)
         PH_HEADER: begin
            magic_in = {magic_ff[23:0], in_byte};
            if (count_ff[3:2] == 2'b01) begin
               total_in = place_byte(total_ff, count_ff[1:0], in_byte);
            end
            count_in = count_ff + 4'd1;
            if (count_in == MAGIC_LEN && magic_in != MAGIC_RIFF) begin
               res.done_res = 1'b1;
               res.status   = 1'b1;
               phase_in     = PH_WAIT;
            end else if (count_in == FILE_HDR_LEN) begin
               if (magic_in != MAGIC_AMS) begin
                  res.done_res = 1'b1;
                  res.status   = 1'b1;
                  phase_in     = PH_WAIT;
               end else begin
                  res.clear_image = 1'b1;
                  go_next         = 1'b1;
               end
            end
         end
         PH_CHUNK_HDR: begin
            chunk_len_in = len_next;
            count_in = count_ff + 4'd1;
            if (count_in == CHUNK_HDR_LEN) begin
               offset_in = offset_ff + 32'(CHUNK_HDR_LEN);
               if (chunk_len_in == 32'd0) begin
                  go_next = 1'b1;
               end else if (page_ff >= PAGE_LIMIT) begin
                  res.done_res = 1'b1;
                  res.status   = 1'b1;
                  phase_in     = PH_WAIT;
               end else begin
                  keep_in      = kept;
                  pos_in       = '0;
                  skip_flag_in = (kept >= PAGE_KEEP) && (32'(kept) < chunk_len_in);
                  // excess up to the padded length, one subtract with carry-in
                  skip_in      = chunk_len_in - 32'(kept) + 32'(chunk_len_in[0]);
                  phase_in     = PH_DATA;
               end
            end
         end
         PH_DATA: begin
            res.write_valid   = 1'b1;
            res.write_data    = in_byte;
            res.write_address = base_ff + ADDR_W'(pos_ff);
            keep_in = keep_ff - KEEP_W'(1);
            pos_in  = pos_ff + KEEP_W'(1);
            if (keep_ff == KEEP_W'(1)) begin
               page_in   = page_ff + PAGE_W'(1);
               base_in   = base_ff + PAGE_STEP;
               offset_in = offset_ff + chunk_len_ff;
               if (skip_flag_ff) begin
                  phase_in = PH_SKIP;
               end else begin
                  go_next = 1'b1;
               end
            end
         end
         PH_SKIP: begin
            skip_in = skip_ff - 32'd1;
            if (skip_ff == 32'd1) begin
               go_next = 1'b1;
            end
         end
         PH_WAIT: begin
         end
         default: begin
         end
      endcase

      // next chunk header or end of the walk
      if (go_next) begin
         if (offset_in < total_in) begin
            phase_in     = PH_CHUNK_HDR;
            count_in     = '0;
            chunk_len_in = '0;
         end else begin
            res.done_res = 1'b1;
            res.status   = 1'b0;
            phase_in     = PH_WAIT;
         end
      end

      // file ends before the load has finished
      if (in_last && !res.done_res && phase_in != PH_WAIT) begin
         res.done_res = 1'b1;
         res.status   = 1'b1;
      end

      if (32'(page_in) > 32'd63) begin
         res.pages_loaded = 6'd63;
      end else begin
         res.pages_loaded = PAGES_W'(page_in);
      end

      // a last byte starts a new file
      if (in_last) begin
         phase_in     = PH_HEADER;
         count_in     = '0;
         magic_in     = '0;
         total_in     = '0;
         offset_in    = HDR_OFFSET;
         chunk_len_in = '0;
         keep_in      = '0;
         pos_in       = '0;
         skip_in      = '0;
         skip_flag_in = 1'b0;
         page_in      = '0;
         base_in      = '0;
      end
   end

   assign result = res;

   // parser state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         magic_ff     <= '0;
         total_ff     <= '0;
         offset_ff    <= HDR_OFFSET;
         chunk_len_ff <= '0;
         keep_ff      <= '0;
         pos_ff       <= '0;
         skip_ff      <= '0;
         skip_flag_ff <= 1'b0;
         page_ff      <= '0;
         base_ff      <= '0;
      end else if (step) begin
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         magic_ff     <= magic_in;
         total_ff     <= total_in;
         offset_ff    <= offset_in;
         chunk_len_ff <= chunk_len_in;
         keep_ff      <= keep_in;
         pos_ff       <= pos_in;
         skip_ff      <= skip_in;
         skip_flag_ff <= skip_flag_in;
         page_ff      <= page_in;
         base_ff      <= base_in;
      end
   end

   // data phase always has bytes left to keep
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> keep_ff != '0)
      else $error("data phase with nothing left to keep");

   // skip phase always has bytes left to skip
   assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_SKIP |-> skip_ff != 32'd0)
      else $error("skip phase with nothing left to skip");

   // page count never passes the page limit
   assert property (@(posedge clock) disable iff (reset)
      page_ff <= PAGE_LIMIT)
      else $error("page index past the page limit");

endmodule

`default_nettype wire

// ----- src/riff_cartridge_chunk_parser.sv -----
// riff_cartridge_chunk_parser: top level with input stage and result register
// depends on rcc_pkg and rcc_parse_core
//
// usage:
//   req_* carries the cartridge file one byte per transaction; req_tlast marks
//   the final byte of a file, and the next byte starts a new file.
//   rsp_* returns exactly one result transaction per input byte, in order:
//   an image write (address, data), the clear-image pulse after a valid file
//   header, the done flag on rsp_tlast with its status, and the page count.
//   order: a byte accepted into the input register is parsed from there, and its
//   result goes into the result register, then out on rsp (input register, then result register).
//   throughput: one byte per cycle while rsp_tready stays high; every step is a
//   handful of compares and counters plus one 32-bit offset add and compare.
//   stall: while rsp_tready is low the result register holds and the input
//   register takes one more byte, then req_tready drops; no result is lost.
//   reset: synchronous, active high; empties both registers and sets the
//   parser to the start of a file.
`default_nettype none

module riff_cartridge_chunk_parser import rcc_pkg::*; #(
   parameter int PAGE_BYTES = DefPageBytes,
   parameter int MAX_PAGES  = DefMaxPages
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // byte stream in
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] file_byte
   input  wire logic        req_tlast,   // last_byte
   // results out
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // [18:0] write_address, [26:19] write_data,
                                         // [32:27] pages_loaded, [39:33] zero
   output logic [2:0]       rsp_tuser,   // [0] write_valid, [1] clear_image, [2] status
   output logic             rsp_tlast    // done_res
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           in_last_ff;
   logic           rsp_valid_ff, rsp_valid_in;
   rcc_result_type rsp_ff;
   rcc_result_type core_res;
   logic           advance;
   logic           req_take;

   // handshake between the input stage and the result register
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_take) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   rcc_parse_core #(
      .PAGE_BYTES (PAGE_BYTES),
      .MAX_PAGES  (MAX_PAGES)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .in_byte (in_byte_ff),
      .in_last (in_last_ff),
      .result  (core_res)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (advance) begin
         rsp_ff <= core_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.pages_loaded, rsp_ff.write_data, rsp_ff.write_address};
   assign rsp_tuser  = {rsp_ff.status, rsp_ff.clear_image, rsp_ff.write_valid};
   assign rsp_tlast  = rsp_ff.done_res;

   // every processed byte shows up as a result
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_tvalid)
      else $error("processed byte without a result");

   // an invalid status only comes with done
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tlast)
      else $error("status without done");

   // the clear pulse never comes with an image write
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1] |-> !rsp_tuser[0])
      else $error("clear pulse together with a write");

endmodule

`default_nettype wire

// ----- tb/sv/tb_riff_cartridge_chunk_parser.sv -----
// tb_riff_cartridge_chunk_parser: self-checking bench for the riff cartridge chunk parser
// drives cartridge files byte by byte and checks every result transaction against a local
// parser model; depends on rcc_pkg and riff_cartridge_chunk_parser
`default_nettype none

module tb_riff_cartridge_chunk_parser import rcc_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int PAGE_SIZE  = DefPageBytes;
   localparam int PAGE_LIMIT = DefMaxPages;
   localparam int unsigned RUN_LIMIT = 1_000_000;
   localparam int PHASE_BYTES = 140;

   // one row of the directed table
   typedef struct {
      bit [7:0]       data;
      bit             last;
      bit             typed;
      rcc_result_type outcome;
   } stim_row_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = 8'd0;   // [7:0] file_byte
   logic        req_tlast  = 1'b0;   // last_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;           // [18:0] write_address, [26:19] write_data,
                                     // [32:27] pages_loaded, [39:33] zero
   logic [2:0]  rsp_tuser;           // [0] write_valid, [1] clear_image, [2] status
   logic        rsp_tlast;           // done_res

   // parser model state
   rcc_phase_type parse_state;
   bit [3:0]      hdr_count;
   bit [31:0]     magic_word;
   bit [31:0]     total_size;
   bit [31:0]     walk_offset;
   bit [31:0]     chunk_size;
   bit [31:0]     keep_left;
   bit [31:0]     skip_left;
   bit [31:0]     page_count;
   bit            load_done;
   bit            load_bad;

   // stimulus and checking state
   rcc_result_type byte_outcomes[$];
   rcc_result_type oldest;
   rcc_result_type quiet_step, failed_step, loaded_step;
   stim_row_type   directed_rows[$];
   bit [7:0]       file_bytes[$];
   bit [31:0]      chunk_lens[$];
   bit [31:0]      data_cap = '1;
   int unsigned    idle_pct = 0;
   int unsigned    stall_pct = 0;
   int unsigned    idle_by_phase[4]  = '{0, 85, 0, 20};
   int unsigned    stall_by_phase[4] = '{0, 0, 85, 20};
   int             sent_in_phase;
   int             mismatches = 0;
   int unsigned    cycle_count = 0;

   riff_cartridge_chunk_parser #(
      .PAGE_BYTES(PAGE_SIZE),
      .MAX_PAGES (PAGE_LIMIT)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ---------------------------------------------------------------- parser model

   task automatic restart_file();
      parse_state = PH_HEADER;
      hdr_count   = 4'd0;
      magic_word  = 32'd0;
      total_size  = 32'd0;
      walk_offset = HDR_OFFSET;
      chunk_size  = 32'd0;
      keep_left   = 32'd0;
      skip_left   = 32'd0;
      page_count  = 32'd0;
   endtask

   task automatic end_load(input bit bad);
      load_done   = 1'b1;
      load_bad    = bad;
      parse_state = PH_WAIT;
   endtask

   // another chunk header follows unless the declared total is reached
   task automatic advance_walk();
      if (walk_offset < total_size) begin
         parse_state = PH_CHUNK_HDR;
         hdr_count   = 4'd0;
         chunk_size  = 32'd0;
      end else begin
         end_load(1'b0);
      end
   endtask

   // bytes of a chunk that land in its page, pad byte included
   function automatic bit [31:0] page_share(input bit [31:0] len);
      bit [31:0] k;
      k = (len < 32'(PAGE_SIZE)) ? len : 32'(PAGE_SIZE);
      if (k[0]) k = k + 32'd1;
      return k;
   endfunction

   task automatic parse_file_byte(input bit [7:0] b, input bit last,
                                  output rcc_result_type res);
      bit [31:0] kept;
      bit [63:0] span;
      res       = '0;
      load_done = 1'b0;
      load_bad  = 1'b0;
      case (parse_state)
         // magic, little-endian total, second magic
         PH_HEADER: begin
            magic_word = {magic_word[23:0], b};
            if (hdr_count >= MAGIC_LEN && hdr_count < CHUNK_HDR_LEN)
               total_size = total_size | ({24'd0, b} << {hdr_count[1:0], 3'b000});
            hdr_count = hdr_count + 4'd1;
            if (hdr_count == MAGIC_LEN && magic_word != MAGIC_RIFF) begin
               end_load(1'b1);
            end else if (hdr_count == FILE_HDR_LEN) begin
               if (magic_word != MAGIC_AMS) begin
                  end_load(1'b1);
               end else begin
                  res.clear_image = 1'b1;
                  advance_walk();
               end
            end
         end
         // tag, then little-endian chunk length
         PH_CHUNK_HDR: begin
            if (hdr_count >= MAGIC_LEN && hdr_count < CHUNK_HDR_LEN)
               chunk_size = chunk_size | ({24'd0, b} << {hdr_count[1:0], 3'b000});
            hdr_count = hdr_count + 4'd1;
            if (hdr_count >= CHUNK_HDR_LEN) begin
               walk_offset = walk_offset + 32'(CHUNK_HDR_LEN);
               kept = page_share(chunk_size);
               if (kept == 32'd0) begin
                  advance_walk();
               end else if (page_count >= 32'(PAGE_LIMIT)) begin
                  end_load(1'b1);
               end else begin
                  keep_left   = kept;
                  parse_state = PH_DATA;
               end
            end
         end
         // bytes that go into the current page
         PH_DATA: begin
            kept = page_share(chunk_size);
            res.write_valid = 1'b1;
            res.write_data  = b;
            span = 64'(page_count) * 64'(PAGE_SIZE) + 64'(kept - keep_left);
            res.write_address = span[ADDR_W-1:0];
            if (keep_left > 32'd0) keep_left = keep_left - 32'd1;
            if (keep_left == 32'd0) begin
               span = 64'd0;
               if (kept >= 32'(PAGE_SIZE) && kept < chunk_size)
                  span = (({32'd0, chunk_size} + 64'd1) & ~64'd1) - 64'(kept);
               page_count  = page_count + 32'd1;
               walk_offset = walk_offset + chunk_size;
               if (span != 64'd0) begin
                  skip_left   = span[31:0];
                  parse_state = PH_SKIP;
               end else begin
                  advance_walk();
               end
            end
         end
         // excess of an oversized chunk
         PH_SKIP: begin
            if (skip_left > 32'd0) skip_left = skip_left - 32'd1;
            if (skip_left == 32'd0) advance_walk();
         end
         default: ;
      endcase
      if (last && !load_done && parse_state != PH_WAIT) end_load(1'b1);
      res.done_res     = load_done;
      res.status       = load_done & load_bad;
      res.pages_loaded = (page_count > 32'd63) ? 6'd63 : page_count[PAGES_W-1:0];
      if (last) restart_file();
   endtask

   // ---------------------------------------------------------------- file builders

   task automatic set_declared_total(input bit [31:0] v);
      for (int k = 0; k < 4; k++) file_bytes[4+k] = v[8*k +: 8];
   endtask

   // well-formed file from chunk_lens; a chunk at or over data_cap is cut and ends the file
   task automatic build_cartridge();
      bit [31:0] total;
      total = HDR_OFFSET;
      file_bytes.delete();
      for (int k = 3; k >= 0; k--) file_bytes.push_back(MAGIC_RIFF[8*k +: 8]);
      repeat (4) file_bytes.push_back(8'd0);
      for (int k = 3; k >= 0; k--) file_bytes.push_back(MAGIC_AMS[8*k +: 8]);
      foreach (chunk_lens[i]) begin
         repeat (4) file_bytes.push_back(8'($urandom));
         for (int k = 0; k < 4; k++) file_bytes.push_back(chunk_lens[i][8*k +: 8]);
         total = total + 32'(CHUNK_HDR_LEN) + chunk_lens[i];
         if (chunk_lens[i] >= data_cap) begin
            repeat (data_cap) file_bytes.push_back(8'($urandom));
            break;
         end
         repeat (chunk_lens[i] + 32'(chunk_lens[i][0])) file_bytes.push_back(8'($urandom));
      end
      set_declared_total(total);
   endtask

   // short nonempty chunks, one page each, with empty ones mixed in
   task automatic build_page_run(input int pages);
      chunk_lens.delete();
      repeat (pages) begin
         if ($urandom_range(3) == 0) chunk_lens.push_back(32'd0);
         chunk_lens.push_back(32'($urandom_range(1, 2)));
      end
      build_cartridge();
   endtask

   // broken variants of a well-formed file, or the file left as it is
   task automatic perturb_file();
      int unsigned r;
      int unsigned pos;
      r = $urandom_range(99);
      if (r < 8) begin
         set_declared_total($urandom);
      end else if (r < 16) begin
         set_declared_total(32'($urandom_range(0, 40)));
      end else if (r < 24) begin
         pos = $urandom_range(7);
         if (pos >= 4) pos = pos + 4;
         file_bytes[pos] = file_bytes[pos] ^ 8'($urandom_range(1, 255));
      end else if (r < 34) begin
         pos = $urandom_range(1, file_bytes.size());
         while (file_bytes.size() > int'(pos)) void'(file_bytes.pop_back());
      end else if (r < 44) begin
         repeat ($urandom_range(1, 4)) file_bytes.push_back(8'($urandom));
      end
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic send_byte(input bit [7:0] b, input bit last, input bit typed,
                            input rcc_result_type typed_out);
      rcc_result_type predicted;
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      parse_file_byte(b, last, predicted);
      byte_outcomes.push_back(typed ? typed_out : predicted);
   endtask

   task automatic send_file();
      for (int i = 0; i < file_bytes.size(); i++) begin
         send_byte(file_bytes[i], i == file_bytes.size() - 1, 1'b0, quiet_step);
         sent_in_phase++;
      end
   endtask

   task automatic random_file();
      int unsigned r;
      r = $urandom_range(99);
      chunk_lens.delete();
      if (r < 70) begin
         // short well-formed file, sometimes broken afterwards
         repeat ($urandom_range(0, 5))
            chunk_lens.push_back(($urandom_range(9) < 3) ? 32'd0 : 32'($urandom_range(1, 20)));
         build_cartridge();
         perturb_file();
      end else if (r < 78) begin
         // empty chunks only
         repeat ($urandom_range(1, 5)) chunk_lens.push_back(32'd0);
         build_cartridge();
      end else if (r < 88) begin
         // noise, either from the first byte or after a valid header
         if ($urandom_range(1) == 1) begin
            file_bytes.delete();
            repeat ($urandom_range(1, 16)) file_bytes.push_back(8'($urandom));
         end else begin
            build_cartridge();
            set_declared_total($urandom);
            repeat ($urandom_range(1, 30)) file_bytes.push_back(8'($urandom));
         end
      end else begin
         // huge chunk length, file ends inside its data
         if ($urandom_range(1) == 1) chunk_lens.push_back(32'($urandom_range(0, 9)));
         chunk_lens.push_back($urandom | 32'h100);
         data_cap = 32'($urandom_range(1, 12));
         build_cartridge();
         data_cap = '1;
      end
      send_file();
   endtask

   // ---------------------------------------------------------------- result checking

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         mismatches++;
      end
   endtask

   // compare each result transaction with the oldest prediction, then pick the next stall
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (byte_outcomes.size() == 0) begin
            $error("result transaction with no byte pending: tdata %0h tuser %0h",
                   rsp_tdata, rsp_tuser);
            mismatches++;
         end else begin
            oldest = byte_outcomes.pop_front();
            check_field("write_valid", 32'(oldest.write_valid), 32'(rsp_tuser[0]));
            check_field("write_address", 32'(oldest.write_address), 32'(rsp_tdata[18:0]));
            check_field("write_data", 32'(oldest.write_data), 32'(rsp_tdata[26:19]));
            check_field("clear_image", 32'(oldest.clear_image), 32'(rsp_tuser[1]));
            check_field("done_res", 32'(oldest.done_res), 32'(rsp_tlast));
            check_field("status", 32'(oldest.status), 32'(rsp_tuser[2]));
            check_field("pages_loaded", 32'(oldest.pages_loaded), 32'(rsp_tdata[32:27]));
            check_field("tdata_pad", 32'd0, 32'(rsp_tdata[39:33]));
         end
      end
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == RUN_LIMIT) begin
         $display("tb_riff_cartridge_chunk_parser NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------- main sequence

   initial begin
      quiet_step  = '0;
      failed_step = '0;
      failed_step.done_res = 1'b1;
      failed_step.status   = 1'b1;
      loaded_step = '0;
      loaded_step.clear_image = 1'b1;
      loaded_step.done_res    = 1'b1;
      restart_file();

      // bad first magic on the 4th byte, then an ignored trailing byte
      directed_rows.push_back('{8'h52, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h49, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h46, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h00, 1'b0, 1'b1, failed_step});
      directed_rows.push_back('{8'hFF, 1'b1, 1'b1, quiet_step});
      // declared total of 12 finishes the load together with the clear
      directed_rows.push_back('{8'h52, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h49, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h46, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h46, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h0C, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h00, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h00, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h00, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h41, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h4D, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h53, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h21, 1'b1, 1'b1, loaded_step});
      // file ends right after a good first magic
      directed_rows.push_back('{8'h52, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h49, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h46, 1'b0, 1'b1, quiet_step});
      directed_rows.push_back('{8'h46, 1'b1, 1'b1, failed_step});

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                   directed_rows[i].outcome);

      for (int ph = 0; ph < 4; ph++) begin
         idle_pct      = idle_by_phase[ph];
         stall_pct     = stall_by_phase[ph];
         sent_in_phase = 0;
         if (ph == 0) begin
            // every page filled, then one nonempty chunk too many
            build_page_run(PAGE_LIMIT + 1);
            send_file();
         end
         while (sent_in_phase < PHASE_BYTES) random_file();
      end
      req_tvalid <= 1'b0;

      while (byte_outcomes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("tb_riff_cartridge_chunk_parser OK");
      end else begin
         $display("tb_riff_cartridge_chunk_parser NOT OK");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ----- filelist.f -----
src/rcc_pkg.sv
src/rcc_parse_core.sv
src/riff_cartridge_chunk_parser.sv
tb/sv/tb_riff_cartridge_chunk_parser.sv
